// File: rtl/grp_pkg.sv
// Shared types, constants and helpers of the guillotine rectangle packer.
// Used by the controller, the datapath, the top level and the checker.
package grp_pkg;

  localparam int MAX_FREE   = 64;
  localparam int COORD_BITS = 16;
  localparam int FIELD_W    = 16;
  localparam int IDX_W      = $clog2(MAX_FREE);
  localparam int CNT_W      = $clog2(MAX_FREE + 1);
  localparam int RECT_W     = 4 * COORD_BITS;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam int AREA_RESET = 1024;

  localparam logic REG_AREA_WIDTH  = 1'b0;
  localparam logic REG_AREA_HEIGHT = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } rect_t;

  typedef enum logic [1:0] {
    STATUS_PLACED = 2'd0,
    STATUS_NOFIT  = 2'd1,
    STATUS_FULL   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_TAKE,
    OP_SCAN,
    OP_DN_START,
    OP_DN,
    OP_DEC,
    OP_SHRINK,
    OP_UP_START,
    OP_UP,
    OP_WR_NODE,
    OP_WR_REM,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic init_pend;
    logic scan_hit;
    logic dn_done;
    logic up_done;
    logic exact;
    logic h_eq;
    logic w_eq;
    logic list_full;
    logic out_full;
  } stat_t;

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic [FIELD_W-1:0] v);
    logic [COORD_BITS-1:0] r;
    if (v > FIELD_W'(COORD_MAX)) begin
      r = COORD_BITS'(COORD_MAX);
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/grp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module grp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/grp_datapath.sv
// Datapath of the rectangle packer: area registers, free list RAM, list
// pointers, the found node, and the result register. Uses grp_pkg and grp_ram.
module grp_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [grp_pkg::PADDR_W-1:0]     paddr,
  input  logic [grp_pkg::PDATA_W-1:0]     pwdata,
  output logic [grp_pkg::PDATA_W-1:0]     prdata,
  input  logic [grp_pkg::FIELD_W-1:0]     rect_width,
  input  logic [grp_pkg::FIELD_W-1:0]     rect_height,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      status,
  output logic [grp_pkg::FIELD_W-1:0]     place_x,
  output logic [grp_pkg::FIELD_W-1:0]     place_y,
  input  grp_pkg::cmd_t                   cmd,
  output grp_pkg::stat_t                  stat
);

  logic [grp_pkg::FIELD_W-1:0]    area_w;
  logic [grp_pkg::FIELD_W-1:0]    area_h;
  logic                           init_pend;
  logic [grp_pkg::CNT_W-1:0]      count;
  logic [grp_pkg::CNT_W-1:0]      ptr;
  logic                           dv;
  logic [grp_pkg::IDX_W-1:0]      didx;
  logic [grp_pkg::FIELD_W-1:0]    req_w;
  logic [grp_pkg::FIELD_W-1:0]    req_h;
  grp_pkg::rect_t                 node;
  logic [grp_pkg::IDX_W-1:0]      fidx;

  logic                           ram_we;
  logic [grp_pkg::IDX_W-1:0]      ram_waddr;
  logic [grp_pkg::RECT_W-1:0]     ram_wdata;
  logic                           ram_re;
  logic [grp_pkg::IDX_W-1:0]      ram_raddr;
  logic [grp_pkg::RECT_W-1:0]     ram_rdata;
  grp_pkg::rect_t                 rd;

  logic                           cfg_wr;
  logic                           fit;
  logic                           dn_issue;
  logic                           up_issue;
  logic [grp_pkg::CNT_W-1:0]      fidx_p1;
  logic [grp_pkg::CNT_W-1:0]      ptr_m1;
  logic [grp_pkg::COORD_BITS-1:0] rw;
  logic [grp_pkg::COORD_BITS-1:0] rh;
  logic                           horiz;
  grp_pkg::rect_t                 shrunk;
  grp_pkg::rect_t                 rem;

  grp_ram #(
    .WIDTH(grp_pkg::RECT_W),
    .DEPTH(grp_pkg::MAX_FREE)
  ) u_free_list (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd      = grp_pkg::rect_t'(ram_rdata);
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (paddr[2] == grp_pkg::REG_AREA_HEIGHT)
                 ? grp_pkg::PDATA_W'(area_h) : grp_pkg::PDATA_W'(area_w);

  assign rw       = req_w[grp_pkg::COORD_BITS-1:0];
  assign rh       = req_h[grp_pkg::COORD_BITS-1:0];
  assign fit      = (grp_pkg::FIELD_W'(rd.w) >= req_w) && (grp_pkg::FIELD_W'(rd.h) >= req_h);
  assign dn_issue = ptr < count;
  assign fidx_p1  = grp_pkg::CNT_W'(fidx) + grp_pkg::CNT_W'(1);
  assign up_issue = ptr > fidx_p1;
  assign ptr_m1   = ptr - grp_pkg::CNT_W'(1);

  assign stat.init_pend = init_pend;
  assign stat.scan_hit  = dv && fit;
  assign stat.dn_done   = !dv && !dn_issue;
  assign stat.up_done   = !dv && !up_issue;
  assign stat.h_eq      = grp_pkg::FIELD_W'(node.h) == req_h;
  assign stat.w_eq      = grp_pkg::FIELD_W'(node.w) == req_w;
  assign stat.exact     = stat.h_eq && stat.w_eq;
  assign stat.list_full = count >= grp_pkg::CNT_W'(grp_pkg::MAX_FREE);
  assign stat.out_full  = out_valid;

  always_comb begin
    horiz = stat.h_eq || (!stat.w_eq && ((node.w - rw) >= (node.h - rh)));
    if (horiz) begin
      shrunk = '{x: node.x + rw, y: node.y, w: node.w - rw, h: node.h};
      rem    = '{x: node.x, y: node.y + rh, w: rw, h: node.h - rh};
    end else begin
      shrunk = '{x: node.x, y: node.y + rh, w: node.w, h: node.h - rh};
      rem    = '{x: node.x + rw, y: node.y, w: node.w - rw, h: rh};
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fidx;
    ram_wdata = shrunk;
    ram_re    = 1'b0;
    ram_raddr = ptr[grp_pkg::IDX_W-1:0];
    case (cmd.op)
      grp_pkg::OP_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = grp_pkg::rect_t'{x: '0, y: '0, w: grp_pkg::sat_coord(area_w),
                                     h: grp_pkg::sat_coord(area_h)};
      end
      grp_pkg::OP_SCAN: begin
        ram_re = dn_issue;
      end
      grp_pkg::OP_DN: begin
        ram_re    = dn_issue;
        ram_we    = dv;
        ram_waddr = didx - grp_pkg::IDX_W'(1);
        ram_wdata = rd;
      end
      grp_pkg::OP_SHRINK: begin
        ram_we = 1'b1;
      end
      grp_pkg::OP_UP: begin
        ram_re    = up_issue;
        ram_raddr = ptr_m1[grp_pkg::IDX_W-1:0];
        ram_we    = dv;
        ram_waddr = didx + grp_pkg::IDX_W'(1);
        ram_wdata = rd;
      end
      grp_pkg::OP_WR_NODE: begin
        ram_we    = 1'b1;
        ram_waddr = fidx_p1[grp_pkg::IDX_W-1:0];
      end
      grp_pkg::OP_WR_REM: begin
        ram_we    = 1'b1;
        ram_wdata = rem;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      area_w    <= grp_pkg::FIELD_W'(grp_pkg::AREA_RESET);
      area_h    <= grp_pkg::FIELD_W'(grp_pkg::AREA_RESET);
      init_pend <= 1'b1;
      count     <= grp_pkg::CNT_W'(1);
      ptr       <= '0;
      dv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        grp_pkg::OP_INIT: begin
          count <= grp_pkg::CNT_W'(1);
          if (!cfg_wr) begin
            init_pend <= 1'b0;
          end
        end
        grp_pkg::OP_TAKE: begin
          ptr <= '0;
          dv  <= 1'b0;
        end
        grp_pkg::OP_SCAN, grp_pkg::OP_DN: begin
          ptr  <= ptr + grp_pkg::CNT_W'(dn_issue);
          dv   <= dn_issue;
          didx <= ptr[grp_pkg::IDX_W-1:0];
        end
        grp_pkg::OP_DN_START: begin
          ptr <= fidx_p1;
          dv  <= 1'b0;
        end
        grp_pkg::OP_DEC: begin
          count <= count - grp_pkg::CNT_W'(1);
        end
        grp_pkg::OP_UP_START: begin
          ptr <= count;
          dv  <= 1'b0;
        end
        grp_pkg::OP_UP: begin
          ptr  <= ptr - grp_pkg::CNT_W'(up_issue);
          dv   <= up_issue;
          didx <= ptr_m1[grp_pkg::IDX_W-1:0];
        end
        grp_pkg::OP_WR_REM: begin
          count <= count + grp_pkg::CNT_W'(1);
        end
        grp_pkg::OP_RESULT: begin
          out_valid <= 1'b1;
        end
        default: begin
        end
      endcase
      if (cfg_wr) begin
        init_pend <= 1'b1;
        if (paddr[2] == grp_pkg::REG_AREA_HEIGHT) begin
          area_h <= pwdata[grp_pkg::FIELD_W-1:0];
        end else begin
          area_w <= pwdata[grp_pkg::FIELD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      grp_pkg::OP_TAKE: begin
        req_w <= rect_width;
        req_h <= rect_height;
      end
      grp_pkg::OP_SCAN: begin
        if (dv && fit) begin
          node <= rd;
          fidx <= didx;
        end
      end
      grp_pkg::OP_RESULT: begin
        status <= cmd.status;
        if (cmd.status == grp_pkg::STATUS_PLACED) begin
          place_x <= grp_pkg::FIELD_W'(node.x);
          place_y <= grp_pkg::FIELD_W'(node.y);
        end else begin
          place_x <= '0;
          place_y <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/grp_ctrl.sv
// Controller state machine of the rectangle packer. Sequences the scan,
// list shifts, node updates and result hand-off. Uses grp_pkg.
module grp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  grp_pkg::stat_t stat,
  output grp_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_DN_START,
    S_DN,
    S_DEC,
    S_SHRINK,
    S_UP_START,
    S_UP,
    S_WR_NODE,
    S_WR_REM,
    S_RESULT
  } state_t;

  state_t            state;
  grp_pkg::status_t  res_status;

  assign in_stall = !(state == S_IDLE && !stat.init_pend);

  always_comb begin
    cmd.status = res_status;
    case (state)
      S_IDLE: begin
        if (stat.init_pend) begin
          cmd.op = grp_pkg::OP_INIT;
        end else if (in_valid) begin
          cmd.op = grp_pkg::OP_TAKE;
        end else begin
          cmd.op = grp_pkg::OP_NONE;
        end
      end
      S_SCAN:     cmd.op = grp_pkg::OP_SCAN;
      S_DN_START: cmd.op = grp_pkg::OP_DN_START;
      S_DN:       cmd.op = grp_pkg::OP_DN;
      S_DEC:      cmd.op = grp_pkg::OP_DEC;
      S_SHRINK:   cmd.op = grp_pkg::OP_SHRINK;
      S_UP_START: cmd.op = grp_pkg::OP_UP_START;
      S_UP:       cmd.op = grp_pkg::OP_UP;
      S_WR_NODE:  cmd.op = grp_pkg::OP_WR_NODE;
      S_WR_REM:   cmd.op = grp_pkg::OP_WR_REM;
      S_RESULT:   cmd.op = stat.out_full ? grp_pkg::OP_NONE : grp_pkg::OP_RESULT;
      default:    cmd.op = grp_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= grp_pkg::STATUS_NOFIT;
    end else begin
      case (state)
        S_IDLE: begin
          if (!stat.init_pend && in_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (stat.scan_hit) begin
            state <= S_DECIDE;
          end else if (stat.dn_done) begin
            res_status <= grp_pkg::STATUS_NOFIT;
            state      <= S_RESULT;
          end
        end
        S_DECIDE: begin
          if (stat.exact) begin
            res_status <= grp_pkg::STATUS_PLACED;
            state      <= S_DN_START;
          end else if (stat.h_eq || stat.w_eq) begin
            res_status <= grp_pkg::STATUS_PLACED;
            state      <= S_SHRINK;
          end else if (stat.list_full) begin
            res_status <= grp_pkg::STATUS_FULL;
            state      <= S_RESULT;
          end else begin
            res_status <= grp_pkg::STATUS_PLACED;
            state      <= S_UP_START;
          end
        end
        S_DN_START: state <= S_DN;
        S_DN: begin
          if (stat.dn_done) begin
            state <= S_DEC;
          end
        end
        S_DEC:      state <= S_RESULT;
        S_SHRINK:   state <= S_RESULT;
        S_UP_START: state <= S_UP;
        S_UP: begin
          if (stat.up_done) begin
            state <= S_WR_NODE;
          end
        end
        S_WR_NODE:  state <= S_WR_REM;
        S_WR_REM:   state <= S_RESULT;
        S_RESULT: begin
          if (!stat.out_full) begin
            state <= S_IDLE;
          end
        end
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/guillotine_rect_packer.sv
// Top level of the guillotine first-fit rectangle packer.
// Instantiates grp_ctrl and grp_datapath; uses grp_pkg.
//
// One request is handled at a time. The free list lives in a RAM with one
// read and one write per cycle: the first-fit scan reads entries up to the
// hit, and the list shift that follows an exact fit or a split reads the
// entries after it, each at one entry per cycle. A result waits in an
// output register, and the next request is taken while it does. After reset
// and after every register write, the list is rebuilt as one node covering
// the area, and no request is taken until it has been rebuilt.
module guillotine_rect_packer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [grp_pkg::PADDR_W-1:0] paddr,
  input  logic [grp_pkg::PDATA_W-1:0] pwdata,
  output logic [grp_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [grp_pkg::FIELD_W-1:0] rect_width,
  input  logic [grp_pkg::FIELD_W-1:0] rect_height,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [grp_pkg::FIELD_W-1:0] place_x,
  output logic [grp_pkg::FIELD_W-1:0] place_y
);

  grp_pkg::cmd_t  cmd;
  grp_pkg::stat_t stat;

  assign pready = 1'b1;

  grp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  grp_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .rect_width (rect_width),
    .rect_height(rect_height),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .place_x    (place_x),
    .place_y    (place_y),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// File: rtl/grp_checker.sv
// Port-level checks for the rectangle packer, bound to the top level.
// Uses grp_pkg.
module grp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        pready,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  status,
  input logic [grp_pkg::FIELD_W-1:0] place_x,
  input logic [grp_pkg::FIELD_W-1:0] place_y
);

  // The block works on one beat at a time, so an accepted beat stalls the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted a second beat while one was in work");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == grp_pkg::STATUS_PLACED || status == grp_pkg::STATUS_NOFIT ||
                   status == grp_pkg::STATUS_FULL))
    else $error("result beat carries an unknown status");

  a_zero_unless_placed: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != grp_pkg::STATUS_PLACED |-> place_x == '0 && place_y == '0)
    else $error("placement nonzero on a result that was not placed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(place_x) &&
                               $stable(place_y))
    else $error("stalled result beat changed");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind guillotine_rect_packer grp_checker u_grp_checker (
  .clk      (clk),
  .rst      (rst),
  .pready   (pready),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .status   (status),
  .place_x  (place_x),
  .place_y  (place_y)
);

// File: tb/grp_tb_pkg.sv
// Scoreboard for the guillotine rectangle packer testbench.
// Holds its own copy of the free list and predicts each placement.
// Depends on grp_pkg for the rectangle and status types and the register constants.
package grp_tb_pkg;
  import grp_pkg::*;

  typedef struct packed {
    status_t              status;
    logic [FIELD_W-1:0]   x;
    logic [FIELD_W-1:0]   y;
  } placement_t;

  class packer_scoreboard;
    rect_t              free_rects[MAX_FREE];
    int                 free_n;
    logic [FIELD_W-1:0] area_w;
    logic [FIELD_W-1:0] area_h;
    placement_t         placements_due[$];
    int                 errors;
    int                 n_placed;
    int                 n_nofit;
    int                 n_full;

    function new();
      area_w = FIELD_W'(AREA_RESET);
      area_h = FIELD_W'(AREA_RESET);
      errors = 0;
      n_placed = 0;
      n_nofit = 0;
      n_full = 0;
      rebuild_list();
    endfunction

    function void rebuild_list();
      int i;
      for (i = 0; i < MAX_FREE; i++) begin
        free_rects[i] = '0;
      end
      free_rects[0].w = (area_w > COORD_MAX) ? COORD_BITS'(COORD_MAX) : area_w[COORD_BITS-1:0];
      free_rects[0].h = (area_h > COORD_MAX) ? COORD_BITS'(COORD_MAX) : area_h[COORD_BITS-1:0];
      free_n = 1;
    endfunction

    function void write_area(input logic idx, input logic [FIELD_W-1:0] value);
      if (idx == REG_AREA_WIDTH) begin
        area_w = value;
      end else begin
        area_h = value;
      end
      rebuild_list();
    endfunction

    // First fit over the free list, then exact take, one-sided shrink or split (list full if no room).
    function void note_request(input logic [FIELD_W-1:0] w, input logic [FIELD_W-1:0] h);
      placement_t p;
      rect_t      n;
      rect_t      rem;
      int         hit;
      int         i;
      hit = -1;
      p.status = STATUS_NOFIT;
      p.x = '0;
      p.y = '0;
      for (i = 0; i < free_n && hit < 0; i++) begin
        if (free_rects[i].w >= w && free_rects[i].h >= h) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        n = free_rects[hit];
        p.status = STATUS_PLACED;
        p.x = n.x;
        p.y = n.y;
        if (n.w == w && n.h == h) begin
          for (i = hit; i < free_n - 1; i++) begin
            free_rects[i] = free_rects[i+1];
          end
          free_rects[free_n-1] = '0;
          free_n--;
        end else if (n.h == h) begin
          free_rects[hit].x = n.x + w;
          free_rects[hit].w = n.w - w;
        end else if (n.w == w) begin
          free_rects[hit].y = n.y + h;
          free_rects[hit].h = n.h - h;
        end else if (free_n >= MAX_FREE) begin
          p.status = STATUS_FULL;
          p.x = '0;
          p.y = '0;
        end else begin
          if ((n.w - w) >= (n.h - h)) begin
            rem.x = n.x;
            rem.y = n.y + h;
            rem.w = w;
            rem.h = n.h - h;
            n.x = n.x + w;
            n.w = n.w - w;
          end else begin
            rem.x = n.x + w;
            rem.y = n.y;
            rem.w = n.w - w;
            rem.h = h;
            n.y = n.y + h;
            n.h = n.h - h;
          end
          for (i = free_n; i > hit; i--) begin
            free_rects[i] = free_rects[i-1];
          end
          free_rects[hit] = rem;
          free_rects[hit+1] = n;
          free_n++;
        end
      end
      case (p.status)
        STATUS_PLACED: n_placed++;
        STATUS_FULL:   n_full++;
        default:       n_nofit++;
      endcase
      placements_due.push_back(p);
    endfunction

    function void check_placement(input logic [1:0] st, input logic [FIELD_W-1:0] x,
                                  input logic [FIELD_W-1:0] y);
      placement_t e;
      if (placements_due.size() == 0) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t: unexpected result beat: status %0d x %0d y %0d", $time, st, x, y);
        end
        return;
      end
      e = placements_due.pop_front();
      if (st !== e.status) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        end
      end
      if (x !== e.x) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t: place_x expected %0d actual %0d", $time, e.x, x);
        end
      end
      if (y !== e.y) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t: place_y expected %0d actual %0d", $time, e.y, y);
        end
      end
    endfunction

    function int pending();
      return placements_due.size();
    endfunction
  endclass

endpackage

// File: tb/tb.sv
// Top-level testbench of guillotine_rect_packer: directed and random rectangle
// requests under random stalls on both sides, with area register changes.
// Depends on grp_pkg and on the scoreboard in grp_tb_pkg.
module tb;
  import grp_pkg::*;
  import grp_tb_pkg::*;

  localparam int  N_ITEMS     = 850;
  localparam int  HOLD_CYCLES = 400;
  localparam int  TAIL_CYCLES = MAX_FREE + 16;
  localparam int  RUN_LIMIT   = 8000000;

  typedef enum int {MIX_STAIR, MIX_ATLAS, MIX_NOISE, MIX_TINY} mix_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [FIELD_W-1:0]   rect_width = '0;
  logic [FIELD_W-1:0]   rect_height = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           status;
  logic [FIELD_W-1:0]   place_x;
  logic [FIELD_W-1:0]   place_y;

  bit                   hold_pending = 1'b0;
  bit                   rx_quiet = 1'b0;
  bit                   tx_quiet = 1'b0;
  int                   n_requests = 0;
  int                   n_settings = 0;
  packer_scoreboard     sb;

  guillotine_rect_packer u_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rect_width (rect_width),
    .rect_height(rect_height),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .place_x    (place_x),
    .place_y    (place_y)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_placement(status, place_x, place_y);
    end
  end

  initial begin
    int r;
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_quiet || r < 60) begin
        out_stall <= 1'b0;
      end else if (r < 95) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb: failure");
    $finish;
  end

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_quiet || r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic request(input logic [FIELD_W-1:0] w, input logic [FIELD_W-1:0] h);
    int gap;
    rect_width <= w;
    rect_height <= h;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(w, h);
    n_requests++;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [FIELD_W-1:0] value);
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= PDATA_W'(value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.write_area(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_area(input logic [FIELD_W-1:0] w, input logic [FIELD_W-1:0] h);
    drain();
    apb_write(REG_AREA_WIDTH, w);
    apb_write(REG_AREA_HEIGHT, h);
    n_settings++;
  endtask

  function automatic logic [FIELD_W-1:0] noise_dim();
    return FIELD_W'($urandom_range(0, 65535) >> $urandom_range(0, 15));
  endfunction

  initial begin
    mix_t mix;
    int   phase;
    int   count;
    int   k;
    int   unit;
    int   sw;
    int   sh;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Default 1024 x 1024 area: oversize requests, exact take, then an empty list.
    request(16'hFFFF, 16'hFFFF);
    request(16'hFFFF, 16'd1);
    request(16'd1024, 16'd1024);
    request(16'd1, 16'd1);

    // Narrow area: shrink from the top, shrink from the left, split, zero sizes.
    set_area(16'd100, 16'd1024);
    request(16'd100, 16'd24);
    request(16'd30, 16'd1000);
    request(16'd10, 16'd10);
    request(16'd70, 16'd5);
    request(16'd0, 16'd0);
    request(16'd0, 16'd10);

    // An area of zero height only takes requests of zero height.
    set_area(16'd100, 16'd0);
    request(16'd1, 16'd1);
    request(16'd0, 16'd0);
    request(16'd5, 16'd0);

    set_area(16'hFFFF, 16'hFFFF);
    request(16'hFFFF, 16'd1);
    request(16'd1, 16'hFFFE);
    request(16'hAAAA, 16'h5555);
    request(16'h5555, 16'hAAAA);
    request(16'h8000, 16'h8000);

    set_area(16'd1, 16'd1);
    request(16'd1, 16'd1);
    request(16'd1, 16'd1);
    request(16'd0, 16'd1);

    phase = 0;
    while (n_requests < N_ITEMS) begin
      mix = (phase == 0) ? MIX_STAIR : mix_t'($urandom_range(0, 3));
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = tx_quiet;
      case (mix)
        MIX_STAIR: begin
          set_area(FIELD_W'($urandom_range(45000, 65535)), FIELD_W'($urandom_range(45000, 65535)));
          count = $urandom_range(66, 76);
        end
        MIX_ATLAS: begin
          unit = 1 << $urandom_range(0, 4);
          set_area(FIELD_W'(unit * $urandom_range(4, 32)), FIELD_W'(unit * $urandom_range(4, 32)));
          count = $urandom_range(30, 60);
        end
        MIX_NOISE: begin
          set_area(FIELD_W'($urandom_range(0, 65535)), FIELD_W'($urandom_range(0, 65535)));
          count = $urandom_range(20, 40);
        end
        default: begin
          set_area(FIELD_W'($urandom_range(0, 6)), FIELD_W'($urandom_range(0, 6)));
          count = $urandom_range(15, 30);
        end
      endcase
      if (phase == 0) begin
        hold_pending = 1'b1;
      end
      sw = $urandom_range(1, 8);
      sh = $urandom_range(1, 8);
      for (k = 0; k < count; k++) begin
        case (mix)
          MIX_STAIR: begin
            // Growing requests never fit an earlier remnant, so each one splits until the list is full.
            if (k < 64) begin
              request(FIELD_W'(sw), FIELD_W'(sh));
            end else begin
              request(FIELD_W'($urandom_range(0, 2 * sw)), FIELD_W'($urandom_range(0, 2 * sh)));
            end
            sw += $urandom_range(1, 8);
            sh += $urandom_range(1, 8);
          end
          MIX_ATLAS: begin
            request(FIELD_W'(unit * $urandom_range(1, 8)), FIELD_W'(unit * $urandom_range(1, 8)));
          end
          MIX_NOISE: begin
            request(noise_dim(), noise_dim());
          end
          default: begin
            request(FIELD_W'($urandom_range(0, 6)), FIELD_W'($urandom_range(0, 6)));
          end
        endcase
        if (!tx_quiet && $urandom_range(0, 63) == 0) begin
          drain();
        end
      end
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("tb: %0d requests over %0d area settings, including a long output hold",
             n_requests, n_settings + 1);
    $display("tb: placed %0d, no fit %0d, list full %0d",
             sb.n_placed, sb.n_nofit, sb.n_full);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
